@@ design/sxma_pkg.sv @@
// shared types and constants for the stun xor-mapped-address parser
package sxma_pkg;

  localparam logic [31:0] STUN_COOKIE  = 32'h2112_A442;
  localparam logic [15:0] XMA_TYPE     = 16'h0020;
  localparam logic [7:0]  FAMILY_IPV4  = 8'h01;
  localparam logic [4:0]  HEADER_BYTES = 5'd20;
  localparam logic [4:0]  ATTR_HDR_BYTES = 5'd4;
  localparam logic [4:0]  ADDR_END     = 5'd12;
  localparam logic [4:0]  FAMILY_POS   = 5'd5;
  localparam logic [4:0]  PORT_POS_HI  = 5'd6;
  localparam logic [4:0]  PORT_POS_LO  = 5'd7;
  localparam logic [4:0]  IP_POS_FIRST = 5'd8;
  localparam logic [15:0] MIN_XMA_LEN  = 16'd8;
  localparam logic [16:0] ADDR_VALUE_BYTES = 17'd8;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ATTR_HDR = 3'd1,
    PH_ADDR     = 3'd2,
    PH_SKIP     = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] mapped_ip;
    logic [15:0] mapped_port;
  } result_t;

  // attribute value length rounded up to a 4-byte boundary
  function automatic logic [16:0] padded_len(input logic [15:0] n);
    logic [16:0] s;
    s = {1'b0, n} + 17'd3;
    return {s[16:2], 2'b00};
  endfunction

endpackage

@@ design/sxma_in_stage.sv @@
// input register stage holding one byte transaction
module sxma_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sxma_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output sxma_pkg::in_item_t item
);

  logic               valid_r, valid_nxt;
  sxma_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

@@ design/sxma_parse.sv @@
// message walker: header skip, attribute tlv walk and address capture
module sxma_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  sxma_pkg::in_item_t item,
  output sxma_pkg::result_t  result
);

  sxma_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  pos_r, pos_nxt, pos_inc;
  logic [15:0] type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [16:0] skip_r, skip_nxt, skip_amt, skip_dec;
  logic [7:0]  fam_r, fam_nxt;
  logic [15:0] port_r, port_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        found_r, found_nxt;
  logic        start_skip;
  logic [7:0]  b;

  assign b        = item.data_byte;
  assign pos_inc  = pos_r + 5'd1;
  assign skip_dec = skip_r - 17'd1;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    skip_nxt   = skip_r;
    fam_nxt    = fam_r;
    port_nxt   = port_r;
    addr_nxt   = addr_r;
    found_nxt  = found_r;
    start_skip = 1'b0;
    skip_amt   = '0;
    case (phase_r)
      sxma_pkg::PH_HEADER: begin
        if (pos_inc >= sxma_pkg::HEADER_BYTES) begin
          pos_nxt   = '0;
          phase_nxt = sxma_pkg::PH_ATTR_HDR;
        end else begin
          pos_nxt = pos_inc;
        end
      end
      sxma_pkg::PH_ATTR_HDR: begin
        if (pos_r < 5'd2) begin
          type_nxt = {type_r[7:0], b};
        end else begin
          len_nxt = {len_r[7:0], b};
        end
        pos_nxt = pos_inc;
        if (pos_inc >= sxma_pkg::ATTR_HDR_BYTES) begin
          if (type_nxt == sxma_pkg::XMA_TYPE && len_nxt >= sxma_pkg::MIN_XMA_LEN) begin
            phase_nxt = sxma_pkg::PH_ADDR;
          end else begin
            start_skip = 1'b1;
            skip_amt   = sxma_pkg::padded_len(len_nxt);
          end
        end
      end
      sxma_pkg::PH_ADDR: begin
        if (pos_r == sxma_pkg::FAMILY_POS) begin
          fam_nxt = b;
        end else if (pos_r == sxma_pkg::PORT_POS_HI || pos_r == sxma_pkg::PORT_POS_LO) begin
          port_nxt = {port_r[7:0], b};
        end else if (pos_r >= sxma_pkg::IP_POS_FIRST) begin
          addr_nxt = {addr_r[23:0], b};
        end
        pos_nxt = pos_inc;
        if (pos_inc >= sxma_pkg::ADDR_END) begin
          if (fam_nxt == sxma_pkg::FAMILY_IPV4) begin
            found_nxt = 1'b1;
            phase_nxt = sxma_pkg::PH_DONE;
          end else begin
            start_skip = 1'b1;
            skip_amt   = sxma_pkg::padded_len(len_r) - sxma_pkg::ADDR_VALUE_BYTES;
          end
        end
      end
      sxma_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          pos_nxt   = '0;
          phase_nxt = sxma_pkg::PH_ATTR_HDR;
        end
      end
      default: begin
      end
    endcase
    // zero-length padded value goes straight to the next attribute header
    if (start_skip) begin
      pos_nxt = '0;
      if (skip_amt == '0) begin
        phase_nxt = sxma_pkg::PH_ATTR_HDR;
      end else begin
        skip_nxt  = skip_amt;
        phase_nxt = sxma_pkg::PH_SKIP;
      end
    end
  end

  always_comb begin
    result.found       = found_nxt;
    result.mapped_ip   = found_nxt ? (addr_nxt ^ sxma_pkg::STUN_COOKIE) : '0;
    result.mapped_port = found_nxt ? (port_nxt ^ sxma_pkg::STUN_COOKIE[31:16]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      phase_r <= sxma_pkg::PH_HEADER;
      pos_r   <= '0;
      type_r  <= '0;
      len_r   <= '0;
      skip_r  <= '0;
      fam_r   <= '0;
      port_r  <= '0;
      addr_r  <= '0;
      found_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      skip_r  <= skip_nxt;
      fam_r   <= fam_nxt;
      port_r  <= port_nxt;
      addr_r  <= addr_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

@@ design/sxma_out_stage.sv @@
// result register holding one result transaction until taken
module sxma_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sxma_pkg::result_t result,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output sxma_pkg::result_t out_result
);

  logic              valid_r, valid_nxt;
  sxma_pkg::result_t result_r;

  assign can_load   = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (can_load) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      result_r <= result;
    end
  end

endmodule

@@ design/stun_xor_mapped_address_parser.sv @@
// top level of the stun xor-mapped-address parser (ipv4)
// Takes a STUN message one byte per transaction on the in_ stream, with
// in_tlast on the final byte, and gives one result transaction per message
// on the out_ stream when that final byte has been processed. The 20-byte
// header is skipped unchecked; attributes are walked as type-length-value
// entries padded to 4 bytes, and the first XOR-MAPPED-ADDRESS (type 0x0020,
// length at least 8, family 0x01) yields the port (xor 0x2112) and the IPv4
// address (xor the magic cookie). A message that ends before that attribute
// is complete reports found = 0 with address and port zero. Throughput is
// one byte per clock while nothing stalls; each byte is held in the input
// register and the parser state is updated as it leaves, and the result
// is loaded into the result register as the last byte leaves. The only
// stall is a full result register holding a previous message's result
// when a final byte arrives; no further bytes are accepted meanwhile.
module stun_xor_mapped_address_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] mapped_ip, [47:32] mapped_port
  output logic        out_tuser   // found
);

  sxma_pkg::in_item_t in_item;
  sxma_pkg::in_item_t item;
  sxma_pkg::result_t  result;
  sxma_pkg::result_t  out_result;
  logic               item_valid;
  logic               advance;
  logic               can_load;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  // a byte leaves the input register unless it is a final byte
  // and the result register is still occupied
  assign advance = item_valid && (!item.last_byte || can_load);

  sxma_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sxma_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  sxma_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && item.last_byte),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {out_result.mapped_port, out_result.mapped_ip};
  assign out_tuser = out_result.found;

endmodule
